// File: src/bbrb_pkg.sv
`default_nettype none
package bbrb_pkg;

    localparam int PIX_W  = 8;
    localparam int KREG_W = 4;
    localparam int IW_W   = 11;
    localparam int IH_W   = 16;

    localparam logic [3:0] MAX_RESULTS = 4'd8;

    // register indexes on the APB port
    localparam logic [1:0] REG_KERNEL_W = 2'd0;
    localparam logic [1:0] REG_KERNEL_H = 2'd1;
    localparam logic [1:0] REG_IMAGE_W  = 2'd2;
    localparam logic [1:0] REG_IMAGE_H  = 2'd3;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_CHK  = 6'b000010,
        ST_SUM  = 6'b000100,
        ST_TAIL = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_PUT  = 6'b100000
    } state_t;

    typedef struct packed {
        logic accept;
        logic finish;
        logic start_res;
        logic sum_step;
        logic tail;
        logic div_step;
        logic put;
    } cmd_t;

    typedef struct packed {
        logic ignore;
        logic more;
        logic sum_last;
        logic div_last;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

// File: src/bbrb_ram.sv
`default_nettype none
module bbrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// File: src/bbrb_ctrl.sv
`default_nettype none
module bbrb_ctrl
    import bbrb_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire sts_t st,
    output cmd_t      cmd
);
    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && !st.ignore) begin
                    cmd.accept = 1'b1;
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                if (st.more) begin
                    cmd.start_res = 1'b1;
                    state_next    = ST_SUM;
                end else begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SUM: begin
                cmd.sum_step = 1'b1;
                if (st.sum_last) begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL: begin
                cmd.tail   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (st.div_last) begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT: begin
                if (st.out_free) begin
                    cmd.put    = 1'b1;
                    state_next = ST_CHK;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire

// File: src/bbrb_dp.sv
`default_nettype none
module bbrb_dp
    import bbrb_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 15
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cmd_t              cmd,
    output sts_t                   st,
    input  wire logic              restart,
    input  wire logic [KREG_W-1:0] kernel_width,
    input  wire logic [KREG_W-1:0] kernel_height,
    input  wire logic [IW_W-1:0]   image_width,
    input  wire logic [IH_W-1:0]   image_height,
    input  wire logic [PIX_W-1:0]  s_pixel_in,
    input  wire logic              s_flush,
    input  wire logic              m_ready,
    output logic                   m_valid,
    output logic [PIX_W-1:0]       m_pixel_out,
    output logic                   m_last_of_run,
    output logic                   m_image_done
);
    localparam int KODD  = (MAX_KERNEL - 1) | 1;
    localparam int KMAX  = (KODD > 15) ? 15 : KODD;
    localparam int DEPTH = KMAX * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CB    = $clog2(MAX_WIDTH);
    localparam int XB    = (CB + 1 > IW_W) ? CB + 1 : IW_W;
    localparam int IRB   = IH_W + 1;
    localparam int RB    = IRB + 2;
    localparam int CXB   = CB + 3;
    localparam int SW    = $clog2(KMAX * KMAX * 255 + 1);
    localparam int DW    = $clog2(KMAX * KMAX + 1);
    localparam int DCB   = $clog2(SW);

    localparam logic [KREG_W-1:0] KMAX_K = KREG_W'(KMAX);
    localparam logic [AW-1:0]     MW_A   = AW'(MAX_WIDTH);
    localparam logic [XB-1:0]     MW_X   = XB'(MAX_WIDTH);

    logic [IRB-1:0]    in_row_reg, in_row_next;
    logic [CB-1:0]     in_col_reg, in_col_next;
    logic [CB:0]       out_col_reg, out_col_next;
    logic [KREG_W-1:0] ring_head_reg, ring_head_next;
    logic [3:0]        n_reg, n_next;
    logic              done_reg, done_next;
    logic [KREG_W-1:0] kx_reg, kx_next, ky_reg, ky_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [SW-1:0]     sum_reg, sum_next;
    logic [DW-1:0]     rem_reg, rem_next;
    logic [DCB-1:0]    dcnt_reg, dcnt_next;
    logic              m_valid_reg, m_valid_next;
    logic [PIX_W-1:0]  m_pixel_reg;
    logic              m_last_reg, m_done_reg;

    // effective geometry
    logic [KREG_W-1:0] kw_or, kh_or, kw, kh;
    logic [2:0]        pw, ph;
    logic [7:0]        area;
    logic [DW-1:0]     divisor;
    logic [XB-1:0]     iw_x, w_x;
    logic [CB:0]       w, w_m1;
    logic [IRB-1:0]    h, h_m1;

    assign kw_or   = kernel_width | KREG_W'(1);
    assign kh_or   = kernel_height | KREG_W'(1);
    assign kw      = (kw_or > KMAX_K) ? KMAX_K : kw_or;
    assign kh      = (kh_or > KMAX_K) ? KMAX_K : kh_or;
    assign pw      = kw[3:1];
    assign ph      = kh[3:1];
    assign area    = {4'd0, kw} * {4'd0, kh};
    assign divisor = area[DW-1:0];
    assign iw_x    = XB'(image_width);
    assign w_x     = (iw_x == '0) ? XB'(1) : ((iw_x > MW_X) ? MW_X : iw_x);
    assign w       = w_x[CB:0];
    assign w_m1    = w - (CB+1)'(1);
    assign h       = (image_height == '0) ? IRB'(1) : IRB'(image_height);
    assign h_m1    = h - IRB'(1);

    // item position
    logic [CB-1:0]  ic;
    logic           row_ok, ic_end;
    logic [IRB-1:0] r;
    logic [CB+1:0]  oc_pw, oc1_pw;
    logic [CB:0]    oc1;

    assign ic     = ({1'b0, in_col_reg} >= w) ? w_m1[CB-1:0] : in_col_reg;
    assign row_ok = in_row_reg >= IRB'(ph);
    assign r      = in_row_reg - IRB'(ph);
    assign ic_end = ({1'b0, ic} == w_m1);
    assign oc1    = out_col_reg + (CB+1)'(1);
    assign oc_pw  = {1'b0, out_col_reg} + (CB+2)'(pw);
    assign oc1_pw = {1'b0, oc1} + (CB+2)'(pw);

    logic more_now, more_after, img_done;
    assign more_now   = row_ok && (n_reg < MAX_RESULTS) &&
                        (ic_end ? (out_col_reg < w) : (oc_pw <= (CB+2)'(ic)));
    assign more_after = row_ok && ((n_reg + 4'd1) < MAX_RESULTS) &&
                        (ic_end ? (oc1 < w) : (oc1_pw <= (CB+2)'(ic)));
    assign img_done   = (r == h_m1) && (out_col_reg == w_m1);

    // window element address
    logic signed [RB-1:0]  ry_raw, back_raw;
    logic [IRB-1:0]        ry;
    logic [KREG_W-1:0]     back;
    logic [KREG_W:0]       slot_sum;
    logic [KREG_W-1:0]     slot;
    logic signed [CXB-1:0] cx_raw;
    logic [CB-1:0]         cx;
    logic [AW-1:0]         raddr, waddr;
    logic [PIX_W-1:0]      rdata;

    assign ry_raw = $signed({2'b00, in_row_reg}) - $signed(RB'({ph, 1'b0}))
                  + $signed(RB'(ky_reg));
    always_comb begin
        if (ry_raw < 0) begin
            ry = '0;
        end else if (ry_raw > $signed({2'b00, h_m1})) begin
            ry = h_m1;
        end else begin
            ry = ry_raw[IRB-1:0];
        end
    end

    assign back_raw = $signed({2'b00, in_row_reg}) - $signed({2'b00, ry});
    always_comb begin
        if (back_raw < 0) begin
            back = '0;
        end else if (back_raw > $signed(RB'(kh - KREG_W'(1)))) begin
            back = kh - KREG_W'(1);
        end else begin
            back = back_raw[KREG_W-1:0];
        end
    end

    assign slot_sum = {1'b0, ring_head_reg} + {1'b0, kh} - {1'b0, back};
    assign slot     = (slot_sum >= {1'b0, kh}) ? KREG_W'(slot_sum - {1'b0, kh})
                                               : slot_sum[KREG_W-1:0];

    assign cx_raw = $signed({2'b00, out_col_reg}) - $signed(CXB'(pw))
                  + $signed(CXB'(kx_reg));
    always_comb begin
        if (cx_raw < 0) begin
            cx = '0;
        end else if (cx_raw > $signed({2'b00, w_m1})) begin
            cx = w_m1[CB-1:0];
        end else begin
            cx = cx_raw[CB-1:0];
        end
    end

    assign raddr = AW'(slot) * MW_A + AW'(cx);
    assign waddr = AW'(ring_head_reg) * MW_A + AW'(ic);

    bbrb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (cmd.accept && !s_flush),
        .waddr (waddr),
        .wdata (s_pixel_in),
        .raddr (raddr),
        .rdata (rdata)
    );

    // restoring divider step, quotient shifts into sum_reg
    logic [DW:0] div_try, div_d;
    logic        div_ge;
    assign div_try = {rem_reg, sum_reg[SW-1]};
    assign div_ge  = div_try >= {1'b0, divisor};
    assign div_d   = div_try - {1'b0, divisor};

    logic [CB:0]       nic;
    logic [KREG_W:0]   head_inc;
    assign nic      = {1'b0, ic} + (CB+1)'(1);
    assign head_inc = {1'b0, ring_head_reg} + (KREG_W+1)'(1);

    always_comb begin
        in_row_next    = in_row_reg;
        in_col_next    = in_col_reg;
        out_col_next   = out_col_reg;
        ring_head_next = ring_head_reg;
        n_next         = n_reg;
        done_next      = done_reg;
        kx_next        = kx_reg;
        ky_next        = ky_reg;
        rd_vld_next    = rd_vld_reg;
        sum_next       = sum_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        m_valid_next   = m_valid_reg && !m_ready;

        if (cmd.accept) begin
            n_next    = '0;
            done_next = 1'b0;
        end
        if (cmd.start_res) begin
            kx_next     = '0;
            ky_next     = '0;
            sum_next    = '0;
            rd_vld_next = 1'b0;
        end
        if (cmd.sum_step) begin
            rd_vld_next = 1'b1;
            if (rd_vld_reg) begin
                sum_next = sum_reg + SW'(rdata);
            end
            if (kx_reg == kw - KREG_W'(1)) begin
                kx_next = '0;
                ky_next = ky_reg + KREG_W'(1);
            end else begin
                kx_next = kx_reg + KREG_W'(1);
            end
        end
        if (cmd.tail) begin
            sum_next    = sum_reg + SW'(rdata);
            rd_vld_next = 1'b0;
            rem_next    = '0;
            dcnt_next   = '0;
        end
        if (cmd.div_step) begin
            rem_next  = div_ge ? div_d[DW-1:0] : div_try[DW-1:0];
            sum_next  = {sum_reg[SW-2:0], div_ge};
            dcnt_next = dcnt_reg + DCB'(1);
        end
        if (cmd.put) begin
            m_valid_next = 1'b1;
            out_col_next = oc1;
            n_next       = n_reg + 4'd1;
            if (img_done) begin
                done_next = 1'b1;
            end
        end
        if (cmd.finish) begin
            if (done_reg) begin
                in_row_next    = '0;
                in_col_next    = '0;
                out_col_next   = '0;
                ring_head_next = '0;
            end else if (nic >= w) begin
                in_col_next    = '0;
                in_row_next    = in_row_reg + IRB'(1);
                ring_head_next = (head_inc == {1'b0, kh}) ? '0
                                                          : head_inc[KREG_W-1:0];
                if (row_ok) begin
                    out_col_next = '0;
                end
            end else begin
                in_col_next = nic[CB-1:0];
            end
        end
        if (restart) begin
            in_row_next    = '0;
            in_col_next    = '0;
            out_col_next   = '0;
            ring_head_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            out_col_reg   <= '0;
            ring_head_reg <= '0;
            n_reg         <= '0;
            done_reg      <= 1'b0;
            kx_reg        <= '0;
            ky_reg        <= '0;
            rd_vld_reg    <= 1'b0;
            dcnt_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            in_row_reg    <= in_row_next;
            in_col_reg    <= in_col_next;
            out_col_reg   <= out_col_next;
            ring_head_reg <= ring_head_next;
            n_reg         <= n_next;
            done_reg      <= done_next;
            kx_reg        <= kx_next;
            ky_reg        <= ky_next;
            rd_vld_reg    <= rd_vld_next;
            dcnt_reg      <= dcnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
        rem_reg <= rem_next;
        if (cmd.put) begin
            m_pixel_reg <= sum_reg[PIX_W-1:0];
            m_last_reg  <= !more_after;
            m_done_reg  <= img_done;
        end
    end

    assign st.ignore   = s_flush ? (in_row_reg < h) : (in_row_reg >= h);
    assign st.more     = more_now;
    assign st.sum_last = (kx_reg == kw - KREG_W'(1)) && (ky_reg == kh - KREG_W'(1));
    assign st.div_last = (dcnt_reg == DCB'(SW - 1));
    assign st.out_free = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_pixel_out   = m_pixel_reg;
    assign m_last_of_run = m_last_reg;
    assign m_image_done  = m_done_reg;

`ifndef SYNTHESIS
    a_put_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.put |-> (!m_valid_reg || m_ready))
        else $error("result loaded over an untaken result");
    a_run_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= MAX_RESULTS)
        else $error("too many results for one request");
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_done_reg) |-> m_last_reg)
        else $error("image end not flagged as last of run");
    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |-> (ring_head_reg < kh))
        else $error("ring head outside kernel height");
`endif
endmodule
`default_nettype wire

// File: src/box_blur_replicate_border.sv
// Channel   Dir  Signals                                        Moves
// s_        in   s_valid s_ready s_pixel_in s_flush              one pixel or flush request
// m_        out  m_valid m_ready m_pixel_out m_last_of_run       one blurred pixel
//                m_image_done
// apb       in   psel penable pwrite paddr pwdata prdata pready  config registers
//
// Steps: a dropped request is only handshaken; any other request is accepted and checked;
// each result then reads its kw*kh window from the line store (one read port, one word
// a cycle), runs restoring division by the window area, and loads the output register.
// Reset: aresetn synchronous, active low; counters clear, line store is not cleared.
// Stalls: the next request is taken while the last result waits in the
// output register; a new result waits only when that register is still full.
`default_nettype none
module box_blur_replicate_border
    import bbrb_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 15
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // pixel requests
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [PIX_W-1:0] s_pixel_in,
    input  wire logic             s_flush,
    // results
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [PIX_W-1:0]      m_pixel_out,
    output logic                  m_last_of_run,
    output logic                  m_image_done,
    // APB config
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [3:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    logic [KREG_W-1:0] kernel_width_reg, kernel_height_reg;
    logic [IW_W-1:0]   image_width_reg;
    logic [IH_W-1:0]   image_height_reg;
    logic              cfg_wr;
    logic [1:0]        cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_width_reg  <= KREG_W'(3);
            kernel_height_reg <= KREG_W'(3);
            image_width_reg   <= IW_W'(1024);
            image_height_reg  <= IH_W'(768);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_KERNEL_W: kernel_width_reg  <= pwdata[KREG_W-1:0];
                REG_KERNEL_H: kernel_height_reg <= pwdata[KREG_W-1:0];
                REG_IMAGE_W:  image_width_reg   <= pwdata[IW_W-1:0];
                REG_IMAGE_H:  image_height_reg  <= pwdata[IH_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_KERNEL_W: prdata = 32'(kernel_width_reg);
            REG_KERNEL_H: prdata = 32'(kernel_height_reg);
            REG_IMAGE_W:  prdata = 32'(image_width_reg);
            REG_IMAGE_H:  prdata = 32'(image_height_reg);
            default:      prdata = '0;
        endcase
    end

    cmd_t cmd;
    sts_t st;

    // sequencer: accept, per-result sum/divide/load, counter update
    bbrb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // line store, window walk, divider, output register
    bbrb_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .st            (st),
        .restart       (cfg_wr),
        .kernel_width  (kernel_width_reg),
        .kernel_height (kernel_height_reg),
        .image_width   (image_width_reg),
        .image_height  (image_height_reg),
        .s_pixel_in    (s_pixel_in),
        .s_flush       (s_flush),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_pixel_out   (m_pixel_out),
        .m_last_of_run (m_last_of_run),
        .m_image_done  (m_image_done)
    );
endmodule
`default_nettype wire
